>>> rtl/kcd_pkg.sv
// shared types and constants for the kernel capability descriptor decoder
`timescale 1ns / 1ps
`default_nettype none

package kcd_pkg;

  typedef enum logic [3:0] {
    KIND_FILLER  = 4'd0,
    KIND_SYSCALL = 4'd1,
    KIND_RELEASE = 4'd2,
    KIND_HANDLES = 4'd3,
    KIND_FLAGS   = 4'd4,
    KIND_HALF    = 4'd5,
    KIND_STATIC  = 4'd6,
    KIND_IO      = 4'd7,
    KIND_SKIPPED = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_INTERRUPT = 2'd1,
    STATUS_CORRUPT   = 2'd2
  } status_t;

  localparam logic [31:0] INTR_MASK    = 32'hF000_0000;
  localparam logic [31:0] INTR_CODE    = 32'hE000_0000;
  localparam logic [31:0] SYSCALL_MASK = 32'hF800_0000;
  localparam logic [31:0] SYSCALL_CODE = 32'hF000_0000;
  localparam logic [31:0] RELEASE_MASK = 32'hFE00_0000;
  localparam logic [31:0] RELEASE_CODE = 32'hFC00_0000;
  localparam logic [31:0] HANDLES_MASK = 32'hFF00_0000;
  localparam logic [31:0] HANDLES_CODE = 32'hFE00_0000;
  localparam logic [31:0] FLAGS_MASK   = 32'hFF80_0000;
  localparam logic [31:0] FLAGS_CODE   = 32'hFF00_0000;
  localparam logic [31:0] STATIC_MASK  = 32'hFFE0_0000;
  localparam logic [31:0] STATIC_CODE  = 32'hFF80_0000;
  localparam logic [31:0] IO_MASK      = 32'hFFF0_0000;
  localparam logic [31:0] IO_CODE      = 32'hFFE0_0000;
  localparam logic [31:0] FILLER_WORD  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [4:0]  position;
    logic        half_pending;
    logic        pending_is_io;
    logic        pending_read_only;
    logic [31:0] pending_start;
    logic [3:0]  mapping_count;
    status_t     error_code;
  } state_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [2:0]  syscall_slot;
    logic [23:0] field_value;
    logic [7:0]  release_major;
    logic [7:0]  release_minor;
    logic [31:0] map_start;
    logic [31:0] map_end;
    logic        map_read_only;
    logic [2:0]  map_index;
    logic        block_end;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/kcd_decode.sv
// descriptor classification and next-state logic for one word
`timescale 1ns / 1ps
`default_nettype none

module kcd_decode import kcd_pkg::*; #(
  parameter int DESCRIPTOR_COUNT = 28,
  parameter int MAX_MAPPINGS     = 8
) (
  input  wire logic [31:0] word,
  input  state_t           cur,
  output state_t           nxt,
  output result_t          res
);

  localparam logic [4:0] LAST_POS = 5'(DESCRIPTOR_COUNT - 1);
  localparam logic [3:0] MAP_MAX  = 4'(MAX_MAPPINGS);

  logic        last;
  logic        ro;
  logic        is_static;
  logic        is_io;
  logic        same;
  logic [31:0] page_addr;
  logic [31:0] end_addr;
  state_t      upd;

  assign last      = cur.position >= LAST_POS;
  assign ro        = word[20];
  assign is_static = (word & STATIC_MASK) == STATIC_CODE;
  assign is_io     = (word & IO_MASK) == IO_CODE;
  // the page address is word bits 19:0 shifted up by 12; word bit 20 is not part of it
  assign page_addr = {word[19:0], 12'h000};

  always_comb begin
    same     = cur.pending_is_io ? is_io : is_static;
    end_addr = page_addr;
    upd      = cur;
    res      = '0;
    res.kind = KIND_SKIPPED;
    if (cur.error_code == STATUS_OK) begin
      if (cur.half_pending) begin
        upd.half_pending = 1'b0;
        if (same && (ro == cur.pending_read_only)) begin
          res.kind          = cur.pending_is_io ? KIND_IO : KIND_STATIC;
          res.map_start     = cur.pending_start;
          res.map_end       = end_addr;
          res.map_read_only = cur.pending_read_only;
          res.map_index     = cur.mapping_count[2:0];
          upd.mapping_count = cur.mapping_count + 4'd1;
        end else begin
          upd.error_code = STATUS_CORRUPT;
        end
      end else if ((word & INTR_MASK) == INTR_CODE) begin
        upd.error_code = STATUS_INTERRUPT;
      end else if ((word & SYSCALL_MASK) == SYSCALL_CODE) begin
        res.kind         = KIND_SYSCALL;
        res.syscall_slot = word[26:24];
        res.field_value  = word[23:0];
      end else if ((word & RELEASE_MASK) == RELEASE_CODE) begin
        res.kind          = KIND_RELEASE;
        res.release_major = word[15:8];
        res.release_minor = word[7:0];
      end else if ((word & HANDLES_MASK) == HANDLES_CODE) begin
        res.kind        = KIND_HANDLES;
        res.field_value = {14'd0, word[9:0]};
      end else if ((word & FLAGS_MASK) == FLAGS_CODE) begin
        res.kind        = KIND_FLAGS;
        res.field_value = {8'd0, word[15:0]};
      end else if (is_static || is_io) begin
        if ((cur.mapping_count >= MAP_MAX) || last) begin
          upd.error_code = STATUS_CORRUPT;
        end else begin
          upd.half_pending      = 1'b1;
          upd.pending_is_io     = is_io;
          upd.pending_read_only = ro;
          upd.pending_start     = page_addr;
          res.kind              = KIND_HALF;
          res.map_start         = page_addr;
          res.map_read_only     = ro;
          res.map_index         = cur.mapping_count[2:0];
        end
      end else if (word == FILLER_WORD) begin
        res.kind = KIND_FILLER;
      end else begin
        upd.error_code = STATUS_CORRUPT;
      end
    end
    res.status    = upd.error_code;
    res.block_end = last;
    if (last) begin
      nxt = '0;
    end else begin
      nxt          = upd;
      nxt.position = cur.position + 5'd1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/kernel_capability_descriptor_decoder_top.sv
// top level: input register, descriptor decode with block state, result register
// Kernel capability descriptor decoder.
// Descriptor words enter on the in_ stream, one 32-bit word per request in
// in_tdata. Each word gives exactly one result on the out_ stream: the kind
// in out_tuser, the decoded fields packed in out_tdata, and out_tlast high
// on the final descriptor of a block of DESCRIPTOR_COUNT words.
// The edge that accepts a request loads the input register; the decoded
// word then moves into the result register, raising out_tvalid, as soon as
// the result register is empty or being read by the receiver.
// Throughput is one descriptor per cycle while out_tready stays high; the
// block state (position, pending mapping half, mapping count, sticky status)
// updates as each word moves from the input register to the result register.
// When the receiver drops out_tready the result register holds, the input
// register fills, and in_tready falls only once both are occupied; no request
// is dropped or repeated.
// Reset (rst_n low, synchronous) empties both registers and clears the block
// state to position zero with no error.
`timescale 1ns / 1ps
`default_nettype none

module kernel_capability_descriptor_decoder_top import kcd_pkg::*; #(
  parameter int DESCRIPTOR_COUNT = 28,
  parameter int MAX_MAPPINGS     = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // descriptor_word
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status, syscall_slot, field_value, release_major, release_minor,
  // map_start, map_end, map_read_only, map_index, zero fill
  output logic [119:0]      out_tdata,
  output logic [3:0]        out_tuser,  // kind
  output logic              out_tlast   // block_end
);

  logic        in_v_r;
  logic [31:0] in_word_r;
  logic        out_v_r;
  result_t     res_r;
  state_t      state_r;
  state_t      state_nxt;
  result_t     res_nxt;
  logic        advance;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  kcd_decode #(
    .DESCRIPTOR_COUNT(DESCRIPTOR_COUNT),
    .MAX_MAPPINGS    (MAX_MAPPINGS)
  ) u_decode (
    .word(in_word_r),
    .cur (state_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        state_r <= state_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_word_r <= in_tdata;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.block_end;
  assign out_tdata  = {7'd0,
                       res_r.map_index,
                       res_r.map_read_only,
                       res_r.map_end,
                       res_r.map_start,
                       res_r.release_minor,
                       res_r.release_major,
                       res_r.field_value,
                       res_r.syscall_slot,
                       res_r.status};

endmodule

`default_nettype wire
